@@ design/pmswb_pkg.sv @@
// ----------------------------------------------------------------------------
// pmswb_pkg
// Shared types, register indexes and the white-balance function for the
// polarizer mosaic splitter.
// ----------------------------------------------------------------------------
package pmswb_pkg;

  // Configuration register indexes.
  localparam logic [2:0] CFG_RAW_ROW_WIDTH = 3'd0;
  localparam logic [2:0] CFG_WIDE_MODE     = 3'd1;
  localparam logic [2:0] CFG_RED_GAIN      = 3'd2;
  localparam logic [2:0] CFG_GREEN_GAIN    = 3'd3;
  localparam logic [2:0] CFG_BLUE_GAIN     = 3'd4;

  localparam logic [12:0] RESET_ROW_WIDTH  = 13'd2448;
  localparam logic [15:0] RESET_RED_GAIN   = 16'd344;
  localparam logic [15:0] RESET_GREEN_GAIN = 16'd255;
  localparam logic [15:0] RESET_BLUE_GAIN  = 16'd731;

  typedef struct packed {
    logic [15:0] pixel;
    logic        frame_start;
  } in_beat_t;

  typedef struct packed {
    logic [15:0] angle_0;
    logic [15:0] angle_45;
    logic [15:0] angle_90;
    logic [15:0] angle_135;
    logic        row_done;
  } out_beat_t;

  // Per-pixel decode of the current raster position.
  typedef struct packed {
    logic store_en;
    logic load_left;
    logic emit;
    logic row_done;
    logic hx;
    logic hy;
  } pos_t;

  // Raw quad with its colour gain, ready for balancing.
  typedef struct packed {
    logic [15:0] raw_0;
    logic [15:0] raw_45;
    logic [15:0] raw_90;
    logic [15:0] raw_135;
    logic [15:0] gain;
    logic        row_done;
  } quad_t;

  // Gain times pixel, then saturate or drop the low byte.
  function automatic logic [15:0] balance(input logic [15:0] px, input logic [15:0] gain,
                                          input logic wide);
    logic [15:0] src;
    logic [31:0] prod;
    logic [15:0] res;
    src  = wide ? px : {8'h00, px[7:0]};
    prod = 32'(gain) * 32'(src);
    if (wide) begin
      res = (prod[31:24] != 8'h00) ? 16'hFFFF : prod[23:8];
    end else begin
      res = (prod[31:16] != 16'h0000) ? 16'h00FF : prod[23:8];
    end
    return res;
  endfunction

endpackage

@@ design/pmswb_tracker.sv @@
// ----------------------------------------------------------------------------
// pmswb_tracker
// Raster position counters, effective row width and the 135-degree holder.
// ----------------------------------------------------------------------------
module pmswb_tracker #(
  parameter int MAX_ROW_PIXELS = 4096
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              beat_take,
  input  pmswb_pkg::in_beat_t               beat,
  input  logic [12:0]                       raw_row_width,
  output pmswb_pkg::pos_t                   pos,
  output logic [$clog2(MAX_ROW_PIXELS)-1:0] col_addr,
  output logic [15:0]                       left_pixel
);
  import pmswb_pkg::*;

  localparam int AW = $clog2(MAX_ROW_PIXELS);
  localparam int CW = (AW + 1 > 13) ? AW + 1 : 13;

  logic [AW-1:0] col_r, col_nxt, col_cur;
  logic [1:0]    phase_r, phase_nxt, phase_cur;
  logic [15:0]   left_r;
  logic [CW-1:0] raw_ext, max_even, width_eff, col_ext, col_inc;
  logic          in_row, last;

  always_comb begin
    col_cur   = beat.frame_start ? '0 : col_r;
    phase_cur = beat.frame_start ? 2'b00 : phase_r;
    raw_ext   = CW'({raw_row_width[12:1], 1'b0});
    max_even  = CW'(MAX_ROW_PIXELS) & ~CW'(1);
    priority if (raw_ext == '0) begin
      width_eff = CW'(2);
    end else if (raw_ext > max_even) begin
      width_eff = max_even;
    end else begin
      width_eff = raw_ext;
    end
    col_ext = CW'(col_cur);
    col_inc = col_ext + CW'(1);
    in_row  = col_ext < width_eff;
    last    = col_inc >= width_eff;

    pos.store_en  = in_row & ~phase_cur[0];
    pos.load_left = in_row & phase_cur[0] & ~col_cur[0];
    pos.emit      = in_row & phase_cur[0] & col_cur[0];
    pos.row_done  = last;
    pos.hx        = col_cur[1];
    pos.hy        = phase_cur[1];

    col_nxt   = last ? '0 : col_inc[AW-1:0];
    phase_nxt = last ? phase_cur + 2'd1 : phase_cur;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r   <= '0;
      phase_r <= 2'b00;
      left_r  <= '0;
    end else if (beat_take) begin
      col_r   <= col_nxt;
      phase_r <= phase_nxt;
      if (pos.load_left) begin
        left_r <= beat.pixel;
      end
    end
  end

  assign col_addr   = col_cur;
  assign left_pixel = left_r;

endmodule

@@ design/pmswb_line_store.sv @@
// ----------------------------------------------------------------------------
// pmswb_line_store
// Line buffer for the even raw row: one write port, two registered reads.
// ----------------------------------------------------------------------------
module pmswb_line_store #(
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [15:0]              wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
  output logic [15:0]              rd_data_a,
  output logic [15:0]              rd_data_b
);
  logic [15:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_a <= mem[rd_addr_a];
      rd_data_b <= mem[rd_addr_b];
    end
  end

endmodule

@@ design/pmswb_balance.sv @@
// ----------------------------------------------------------------------------
// pmswb_balance
// Four gain multipliers with saturation, feeding the result register.
// ----------------------------------------------------------------------------
module pmswb_balance (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 quad_valid,
  input  pmswb_pkg::quad_t     quad,
  input  logic                 wide_mode,
  output logic                 quad_take,
  output logic                 out_valid,
  input  logic                 out_stall,
  output pmswb_pkg::out_beat_t out_data
);
  import pmswb_pkg::*;

  logic      out_valid_r;
  out_beat_t out_data_r, out_data_nxt;

  assign quad_take = ~out_valid_r | ~out_stall;

  always_comb begin
    out_data_nxt.angle_0   = balance(quad.raw_0, quad.gain, wide_mode);
    out_data_nxt.angle_45  = balance(quad.raw_45, quad.gain, wide_mode);
    out_data_nxt.angle_90  = balance(quad.raw_90, quad.gain, wide_mode);
    out_data_nxt.angle_135 = balance(quad.raw_135, quad.gain, wide_mode);
    out_data_nxt.row_done  = quad.row_done;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (quad_take) begin
      out_valid_r <= quad_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (quad_take && quad_valid) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

@@ design/polarizer_mosaic_split_white_balance.sv @@
// ----------------------------------------------------------------------------
// polarizer_mosaic_split_white_balance
// Splits a 2x2 polarizer-mosaic raw stream into white-balanced angle quads.
// ----------------------------------------------------------------------------
// Raw pixels arrive in raster order, one beat each, and the block takes one
// beat every clock while in_stall is low. Even raw rows go into an on-chip
// line buffer; at every odd column of an odd raw row one output beat carries
// the four angle pixels of that 2x2 cell (0, 45, 90 and 135 degrees), each
// scaled by the RGGB gain of the cell's half-resolution position and
// saturated. The beat that completes a cell is registered in the quad stage
// beside the line buffer's registered read, then passes through the
// multipliers into the output register. The line buffer needs no clearing
// after reset, since every entry is written by an even row before it is read.
// Assert frame_start on the first pixel of a frame to restart the raster
// counters. Write configuration only while the stream is idle.
// ----------------------------------------------------------------------------
module polarizer_mosaic_split_white_balance #(
  parameter int MAX_ROW_PIXELS = 4096
) (
  input  logic                 clk,
  input  logic                 rst_n,
  // Pixel input channel.
  input  logic                 in_valid,
  output logic                 in_stall,
  input  pmswb_pkg::in_beat_t  in_data,
  // Quad output channel.
  output logic                 out_valid,
  input  logic                 out_stall,
  output pmswb_pkg::out_beat_t out_data,
  // Configuration write channel.
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [2:0]           cfg_index,
  input  logic [15:0]          cfg_data
);
  import pmswb_pkg::*;

  localparam int AW = $clog2(MAX_ROW_PIXELS);

  // Configuration registers.
  logic [12:0] raw_row_width_r;
  logic        wide_mode_r;
  logic [15:0] red_gain_r, green_gain_r, blue_gain_r;

  // The config port never back-pressures.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      raw_row_width_r <= RESET_ROW_WIDTH;
      wide_mode_r     <= 1'b0;
      red_gain_r      <= RESET_RED_GAIN;
      green_gain_r    <= RESET_GREEN_GAIN;
      blue_gain_r     <= RESET_BLUE_GAIN;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_RAW_ROW_WIDTH: raw_row_width_r <= cfg_data[12:0];
        CFG_WIDE_MODE:     wide_mode_r     <= cfg_data[0];
        CFG_RED_GAIN:      red_gain_r      <= cfg_data;
        CFG_GREEN_GAIN:    green_gain_r    <= cfg_data;
        CFG_BLUE_GAIN:     blue_gain_r     <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Input acceptance. The quad stage holds at most one cell; it frees up in
  // the same cycle the balance stage takes it, so a full pipe still runs at
  // one beat per clock unless the output stalls.
  logic    accept;
  logic    quad_take;
  logic    quad_valid_r;
  pos_t    pos;
  logic [AW-1:0] col_addr;
  logic [15:0]   left_pixel;

  assign in_stall = quad_valid_r & ~quad_take;
  assign accept   = in_valid & ~in_stall;

  pmswb_tracker #(
    .MAX_ROW_PIXELS(MAX_ROW_PIXELS)
  ) u_tracker (
    .clk          (clk),
    .rst_n        (rst_n),
    .beat_take    (accept),
    .beat         (in_data),
    .raw_row_width(raw_row_width_r),
    .pos          (pos),
    .col_addr     (col_addr),
    .left_pixel   (left_pixel)
  );

  // The upper row of the cell comes from the line buffer at the current
  // column (45 degrees) and the column before it (90 degrees).
  logic [15:0] upper_right, upper_left;

  pmswb_line_store #(
    .DEPTH(MAX_ROW_PIXELS)
  ) u_line_store (
    .clk      (clk),
    .wr_en    (accept & pos.store_en),
    .wr_addr  (col_addr),
    .wr_data  (in_data.pixel),
    .rd_en    (accept & pos.emit),
    .rd_addr_a(col_addr),
    .rd_addr_b(col_addr - AW'(1)),
    .rd_data_a(upper_right),
    .rd_data_b(upper_left)
  );

  // Colour of the cell from its half-resolution position (RGGB).
  logic [15:0] gain_sel;

  always_comb begin
    unique case ({pos.hy, pos.hx})
      2'b00:   gain_sel = red_gain_r;
      2'b11:   gain_sel = blue_gain_r;
      default: gain_sel = green_gain_r;
    endcase
  end

  // Quad stage: the lower row of the cell and its gain are captured beside
  // the line buffer's registered read.
  logic [15:0] raw_0_r, raw_135_r, gain_r;
  logic        row_done_r;
  quad_t       quad;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      quad_valid_r <= 1'b0;
    end else if (accept) begin
      quad_valid_r <= pos.emit;
    end else if (quad_take) begin
      quad_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && pos.emit) begin
      raw_0_r    <= in_data.pixel;
      raw_135_r  <= left_pixel;
      gain_r     <= gain_sel;
      row_done_r <= pos.row_done;
    end
  end

  always_comb begin
    quad.raw_0    = raw_0_r;
    quad.raw_45   = upper_right;
    quad.raw_90   = upper_left;
    quad.raw_135  = raw_135_r;
    quad.gain     = gain_r;
    quad.row_done = row_done_r;
  end

  pmswb_balance u_balance (
    .clk       (clk),
    .rst_n     (rst_n),
    .quad_valid(quad_valid_r),
    .quad      (quad),
    .wide_mode (wide_mode_r),
    .quad_take (quad_take),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
